// ===== hw/rtl/kmp_pkg.sv =====
// Package for the key match probe block: shared constants, request codes,
// controller state type and the command/status structs between controller
// and datapath. No dependencies.
`default_nettype none

package kmp_pkg;

  // Default sizes of the build-side key table.
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned KeyWidthDef   = 32;

  // Fixed field widths.
  localparam int unsigned CfgW      = 7;
  localparam int unsigned EntryIdxW = 6;
  localparam int unsigned CountW    = 32;

  localparam logic [CountW-1:0] CountMax = 32'hFFFF_FFFF;

  // Request type codes.
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqProbe = 1'b1;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } kmp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;      // write the request key into the table
    logic probe_start;  // capture the match vector of the request key
    logic emit;         // send the next result to the output register
  } kmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic last_pick;  // the result picked now is the final one of the probe
  } kmp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/key_match_probe_unit.sv =====
// Top level of the key match probe block: instantiates the controller and
// the datapath. Depends on kmp_pkg, kmp_ctrl and kmp_datapath.
//
// Nested-loop join probe against a small key table. A load request writes
// its key into one table entry. A probe request compares its key against
// all entries in use at once as it is accepted, then sends one result per
// matching entry, lowest index first, one per cycle while the output is not
// stalled, through a single output register; a probe with no match sends
// one result with found clear. The next request is accepted in the cycle
// the final result of a probe is sent. The running batch match total
// saturates and is reported, then cleared, on the final result of the probe
// marked end of batch. Table entries have no reset and must be loaded
// before they are probed; there is no clearing pass.
`default_nettype none

module key_match_probe_unit #(
  parameter int unsigned TABLE_DEPTH = kmp_pkg::TableDepthDef,
  parameter int unsigned KEY_WIDTH   = kmp_pkg::KeyWidthDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port.
  input  wire logic                                cfg_we_i,
  input  wire logic        [kmp_pkg::CfgW-1:0]     cfg_wdata_i,
  // Request channel.
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                req_type_i,
  input  wire logic        [kmp_pkg::EntryIdxW-1:0] entry_index_i,
  input  wire logic signed [KEY_WIDTH-1:0]         key_i,
  input  wire logic                                end_of_batch_i,
  // Result channel.
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     found_o,
  output logic             [kmp_pkg::EntryIdxW-1:0] match_index_o,
  output logic                                     last_of_probe_o,
  output logic                                     batch_done_o,
  output logic             [kmp_pkg::CountW-1:0]   batch_match_count_o
);

  kmp_pkg::kmp_cmd_t    cmd;
  kmp_pkg::kmp_status_t status;

  // Controller.
  kmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  kmp_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .entry_index_i       (entry_index_i),
    .key_i               (key_i),
    .end_of_batch_i      (end_of_batch_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .found_o             (found_o),
    .match_index_o       (match_index_o),
    .last_of_probe_o     (last_of_probe_o),
    .batch_done_o        (batch_done_o),
    .batch_match_count_o (batch_match_count_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/kmp_ctrl.sv =====
// Controller state machine of the key match probe block.
// Depends on kmp_pkg for the state type and the command/status structs.
`default_nettype none

module kmp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                req_type_i,
  output logic                     in_stall_o,
  input  wire kmp_pkg::kmp_status_t status_i,
  output kmp_pkg::kmp_cmd_t        cmd_o
);

  kmp_pkg::kmp_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    logic take_req;
    take_req    = 1'b0;
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    case (state_q)
      kmp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        take_req   = in_valid_i;
      end
      kmp_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          // The final result frees the datapath, so a new request may enter now.
          if (status_i.last_pick) begin
            in_stall_o = 1'b0;
            state_d    = kmp_pkg::ST_IDLE;
            take_req   = in_valid_i;
          end
        end
      end
      default: begin
        state_d = kmp_pkg::ST_IDLE;
      end
    endcase

    // Decode an accepted request.
    if (take_req) begin
      if (req_type_i == kmp_pkg::ReqLoad) begin
        cmd_o.load_we = 1'b1;
      end else begin
        cmd_o.probe_start = 1'b1;
        state_d           = kmp_pkg::ST_EMIT;
      end
    end
  end

`ifndef SYNTHESIS
  // A request is only taken in the emit state together with the final result.
  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmp_pkg::ST_EMIT && !in_stall_o) |-> (cmd_o.emit && status_i.last_pick))
    else $error("request accepted before the probe finished");

  // No results are sent while idle.
  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmp_pkg::ST_IDLE) |-> !cmd_o.emit)
    else $error("result emitted while idle");

  // A started probe always moves on to sending results.
  a_probe_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.probe_start |=> (state_q == kmp_pkg::ST_EMIT))
    else $error("probe start did not enter the emit state");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/kmp_datapath.sv =====
// Datapath of the key match probe block: key table, parallel key compare,
// match vector, lowest-match pick, batch match counter and output register.
// Depends on kmp_pkg for widths, constants and the command/status structs.
`default_nettype none

module kmp_datapath #(
  parameter int unsigned TABLE_DEPTH = kmp_pkg::TableDepthDef,
  parameter int unsigned KEY_WIDTH   = kmp_pkg::KeyWidthDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic        [kmp_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic        [kmp_pkg::EntryIdxW-1:0] entry_index_i,
  input  wire logic signed [KEY_WIDTH-1:0]         key_i,
  input  wire logic                                end_of_batch_i,
  input  wire kmp_pkg::kmp_cmd_t                   cmd_i,
  output kmp_pkg::kmp_status_t                     status_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     found_o,
  output logic             [kmp_pkg::EntryIdxW-1:0] match_index_o,
  output logic                                     last_of_probe_o,
  output logic                                     batch_done_o,
  output logic             [kmp_pkg::CountW-1:0]   batch_match_count_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [kmp_pkg::CfgW-1:0] DepthCfg = kmp_pkg::CfgW'(TABLE_DEPTH);

  logic signed [KEY_WIDTH-1:0]         table_q [TABLE_DEPTH];
  logic        [kmp_pkg::CfgW-1:0]     entries_q;
  logic        [kmp_pkg::CfgW-1:0]     limit;
  logic        [TABLE_DEPTH-1:0]       hit_vec;
  logic        [TABLE_DEPTH-1:0]       match_q, match_d;
  logic        [TABLE_DEPTH-1:0]       low_bit;
  logic        [TABLE_DEPTH-1:0]       rest;
  logic        [IdxW-1:0]              pick_idx;
  logic                                pick_found;
  logic                                eob_q;
  logic        [kmp_pkg::CountW-1:0]   count_q, count_d;
  logic        [kmp_pkg::CountW-1:0]   count_inc;
  logic                                load_ok;
  logic                                out_valid_q;
  logic                                found_q;
  logic        [kmp_pkg::EntryIdxW-1:0] match_index_q;
  logic                                last_q;
  logic                                done_q;
  logic        [kmp_pkg::CountW-1:0]   total_q;

  // Entry count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  assign limit = (entries_q > DepthCfg) ? DepthCfg : entries_q;

  // Key table write; loads beyond the table depth are dropped.
  assign load_ok = ({1'b0, entry_index_i} < DepthCfg);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && load_ok) begin
      table_q[entry_index_i[IdxW-1:0]] <= key_i;
    end
  end

  // One comparator per table entry, masked by the entry count.
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      hit_vec[j] = (table_q[j] == key_i) && (kmp_pkg::CfgW'(j) < limit);
    end
  end

  // Isolate the lowest pending match and encode its index.
  assign low_bit    = match_q & (~match_q + 1'b1);
  assign rest       = match_q & ~low_bit;
  assign pick_found = |match_q;

  always_comb begin
    pick_idx = '0;
    for (int b = 0; b < IdxW; b++) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (((j >> b) & 1) == 1) begin
          pick_idx[b] = pick_idx[b] | low_bit[j];
        end
      end
    end
  end

  assign status_o.last_pick = (rest == '0);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Pending match vector.
  always_comb begin
    match_d = match_q;
    if (cmd_i.emit) begin
      match_d = rest;
    end
    if (cmd_i.probe_start) begin
      match_d = hit_vec;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    if (cmd_i.probe_start) begin
      eob_q <= end_of_batch_i;
    end
  end

  // Saturating batch match counter, cleared after the end-of-batch report.
  assign count_inc = (pick_found && count_q != kmp_pkg::CountMax) ? count_q + 1'b1
                                                                  : count_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.emit) begin
      count_d = (status_o.last_pick && eob_q) ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q       <= pick_found;
      match_index_q <= kmp_pkg::EntryIdxW'(pick_idx);
      last_q        <= status_o.last_pick;
      done_q        <= status_o.last_pick && eob_q;
      total_q       <= (status_o.last_pick && eob_q) ? count_inc : '0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign found_o             = found_q;
  assign match_index_o       = match_index_q;
  assign last_of_probe_o     = last_q;
  assign batch_done_o        = done_q;
  assign batch_match_count_o = total_q;

`ifndef SYNTHESIS
  // A result is only written into a free output register.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> status_o.out_free)
    else $error("result overwrote a waiting output");

  // The batch report only comes on the final result of a probe.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> last_q)
    else $error("batch report on a result that is not final");

  // The batch counter is empty right after a batch report is produced.
  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && status_o.last_pick && eob_q) |=> (count_q == '0))
    else $error("batch counter not cleared after batch report");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_key_match_probe_unit.sv =====
// Self-checking testbench for key_match_probe_unit: loads the key table,
// probes it under several entry counts and stall patterns, and checks every
// match result against a predictor kept in the bench. Depends on kmp_pkg.
`default_nettype none

module tb_key_match_probe_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit   = 2000;
  localparam int SegmentItems = 40;

  typedef struct packed {
    logic                          found;
    logic [kmp_pkg::EntryIdxW-1:0] match_index;
    logic                          last_of_probe;
    logic                          batch_done;
    logic [kmp_pkg::CountW-1:0]    batch_match_count;
  } probe_result_t;

  // Mirrors the key table and the batch total, and holds the match results
  // still owed by the block, oldest first.
  class ProbeMatchTracker;
    logic [31:0]                table_keys [kmp_pkg::TableDepthDef];
    logic [kmp_pkg::CfgW-1:0]   entries_in_use;
    logic [kmp_pkg::CountW-1:0] batch_total;
    probe_result_t              owed_matches [$];
    int unsigned                mismatch_count;

    function new();
      entries_in_use = '0;
      batch_total    = '0;
      mismatch_count = 0;
      foreach (table_keys[i]) table_keys[i] = '0;
    endfunction

    function void set_entries(logic [kmp_pkg::CfgW-1:0] value);
      entries_in_use = value;
    endfunction

    function int pending();
      return owed_matches.size();
    endfunction

    // Applies one accepted request and queues the results it must produce.
    function void note_request(logic rt, logic [kmp_pkg::EntryIdxW-1:0] idx,
                               logic [31:0] key, logic eob);
      probe_result_t this_probe [$];
      probe_result_t r;
      int unsigned   span;
      logic [kmp_pkg::CountW:0] sum;
      if (rt == kmp_pkg::ReqLoad) begin
        if (idx < kmp_pkg::TableDepthDef) table_keys[idx] = key;
        return;
      end
      span = (entries_in_use > kmp_pkg::TableDepthDef) ? kmp_pkg::TableDepthDef
                                                       : entries_in_use;
      for (int j = 0; j < span; j++) begin
        if (table_keys[j] == key) begin
          r = '0;
          r.found = 1'b1;
          r.match_index = kmp_pkg::EntryIdxW'(j);
          this_probe = {this_probe, r};
        end
      end
      // The batch total saturates rather than wrapping.
      sum = {1'b0, batch_total} + (kmp_pkg::CountW + 1)'(this_probe.size());
      batch_total = sum[kmp_pkg::CountW] ? kmp_pkg::CountMax : sum[kmp_pkg::CountW-1:0];
      if (this_probe.size() == 0) this_probe = {this_probe, probe_result_t'('0)};
      r = this_probe.pop_back();
      r.last_of_probe = 1'b1;
      if (eob) begin
        r.batch_done = 1'b1;
        r.batch_match_count = batch_total;
        batch_total = '0;
      end
      this_probe = {this_probe, r};
      owed_matches = {owed_matches, this_probe};
    endfunction

    // Compares one accepted result with the oldest owed one, field by field.
    function void check_match(probe_result_t got);
      probe_result_t want;
      if (owed_matches.size() == 0) begin
        $display("%0t: unexpected result found=%0d index=%0d last=%0d done=%0d count=%0d",
                 $time, got.found, got.match_index, got.last_of_probe, got.batch_done,
                 got.batch_match_count);
        mismatch_count++;
        return;
      end
      want = owed_matches.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
        mismatch_count++;
      end
      if (got.match_index !== want.match_index) begin
        $display("%0t: match_index expected %0d actual %0d", $time, want.match_index,
                 got.match_index);
        mismatch_count++;
      end
      if (got.last_of_probe !== want.last_of_probe) begin
        $display("%0t: last_of_probe expected %0d actual %0d", $time, want.last_of_probe,
                 got.last_of_probe);
        mismatch_count++;
      end
      if (got.batch_done !== want.batch_done) begin
        $display("%0t: batch_done expected %0d actual %0d", $time, want.batch_done,
                 got.batch_done);
        mismatch_count++;
      end
      if (got.batch_match_count !== want.batch_match_count) begin
        $display("%0t: batch_match_count expected %0d actual %0d", $time,
                 want.batch_match_count, got.batch_match_count);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   cfg_we = 1'b0;
  logic [kmp_pkg::CfgW-1:0]               cfg_wdata = '0;
  logic                                   in_valid = 1'b0;
  logic                                   in_stall_o;
  logic                                   req_type = kmp_pkg::ReqLoad;
  logic [kmp_pkg::EntryIdxW-1:0]          entry_index = '0;
  logic signed [kmp_pkg::KeyWidthDef-1:0] req_key = '0;
  logic                                   end_of_batch = 1'b0;
  logic                                   out_valid_o;
  logic                                   out_stall = 1'b0;
  logic                                   found_o;
  logic [kmp_pkg::EntryIdxW-1:0]          match_index_o;
  logic                                   last_of_probe_o;
  logic                                   batch_done_o;
  logic [kmp_pkg::CountW-1:0]             batch_match_count_o;

  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      quiet_cycles = 0;
  logic [31:0]      key_pool [8];
  ProbeMatchTracker tracker;

  key_match_probe_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type),
    .entry_index_i       (entry_index),
    .key_i               (req_key),
    .end_of_batch_i      (end_of_batch),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .found_o             (found_o),
    .match_index_o       (match_index_o),
    .last_of_probe_o     (last_of_probe_o),
    .batch_done_o        (batch_done_o),
    .batch_match_count_o (batch_match_count_o)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver back-pressure, redrawn on every falling edge.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      tracker.check_match(probe_result_t'({found_o, match_index_o, last_of_probe_o,
                                           batch_done_o, batch_match_count_o}));
    end
  end

  // Watchdog: ends the run when no request and no result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_key_match_probe_unit: errors");
      $finish;
    end
  end

  // Presents one request, with random idle cycles ahead of it, and holds it
  // until the block takes it.
  task automatic issue_request(input logic rt, input logic [kmp_pkg::EntryIdxW-1:0] idx,
                               input logic [31:0] key, input logic eob);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    req_type     <= rt;
    entry_index  <= idx;
    req_key      <= key;
    end_of_batch <= eob;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_request(rt, idx, key, eob);
  endtask

  // Stops sending and waits until every owed result has come back.
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Changes the entry count once the block is idle; a trailing load may still
  // be in flight, so the task waits before writing.
  task automatic write_entries_in_use(input logic [kmp_pkg::CfgW-1:0] value);
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    tracker.set_entries(value);
  endtask

  initial begin
    logic                          rt;
    logic [kmp_pkg::EntryIdxW-1:0] idx;
    logic [31:0]                   key;
    logic                          eob;
    logic [kmp_pkg::CfgW-1:0]      entries;

    tracker = new();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a four-entry table with a duplicated key; loads carrying the
    // end-of-batch flag must leave the batch total alone.
    write_entries_in_use(7'd4);
    issue_request(kmp_pkg::ReqLoad, 6'd0, 32'h8000_0000, 1'b1);
    issue_request(kmp_pkg::ReqLoad, 6'd1, 32'h7FFF_FFFF, 1'b0);
    issue_request(kmp_pkg::ReqLoad, 6'd2, 32'h7FFF_FFFF, 1'b0);
    issue_request(kmp_pkg::ReqLoad, 6'd3, 32'h0000_0000, 1'b1);
    issue_request(kmp_pkg::ReqLoad, 6'd63, 32'hFFFF_FFFF, 1'b0);
    issue_request(kmp_pkg::ReqProbe, 6'd0, 32'h7FFF_FFFF, 1'b0);
    issue_request(kmp_pkg::ReqProbe, 6'd17, 32'h8000_0000, 1'b0);
    issue_request(kmp_pkg::ReqProbe, 6'd63, 32'h1234_5678, 1'b0);
    issue_request(kmp_pkg::ReqProbe, 6'd63, 32'h0000_0000, 1'b1);
    // Entry 63 holds the key but lies beyond the entries in use.
    issue_request(kmp_pkg::ReqProbe, 6'd0, 32'hFFFF_FFFF, 1'b1);

    // An empty table: every probe misses.
    write_entries_in_use(7'd0);
    issue_request(kmp_pkg::ReqProbe, 6'd0, 32'h0000_0000, 1'b1);
    issue_request(kmp_pkg::ReqProbe, 6'd42, 32'h7FFF_FFFF, 1'b0);

    // Every entry equal: a probe yields the full 64 results.
    for (int i = 0; i < kmp_pkg::TableDepthDef; i++) begin
      issue_request(kmp_pkg::ReqLoad, kmp_pkg::EntryIdxW'(i), 32'hFFFF_FFFF, 1'b0);
    end
    write_entries_in_use(7'd64);
    issue_request(kmp_pkg::ReqProbe, 6'd0, 32'hFFFF_FFFF, 1'b1);
    // An entry count past the table depth is clipped to the depth.
    write_entries_in_use(7'd127);
    issue_request(kmp_pkg::ReqProbe, 6'd5, 32'hFFFF_FFFF, 1'b0);
    issue_request(kmp_pkg::ReqProbe, 6'd5, 32'h0000_0000, 1'b0);
    issue_request(kmp_pkg::ReqProbe, 6'd5, 32'hFFFF_FFFF, 1'b1);
    write_entries_in_use(7'd1);
    issue_request(kmp_pkg::ReqProbe, 6'd0, 32'hFFFF_FFFF, 1'b1);

    // Refill the table from a small key pool so that probes see duplicates.
    for (int i = 0; i < kmp_pkg::TableDepthDef; i++) begin
      issue_request(kmp_pkg::ReqLoad, kmp_pkg::EntryIdxW'(i), key_pool[$urandom_range(7)],
                    1'($urandom_range(1)));
    end

    // Random segments, each setting an entry count and an idle and stall pattern.
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0, 4:    entries = 7'd64;
        1:       entries = 7'd1;
        2:       entries = 7'd127;
        3:       entries = 7'd0;
        5:       entries = kmp_pkg::CfgW'($urandom_range(63, 2));
        6:       entries = kmp_pkg::CfgW'($urandom_range(126, 65));
        default: entries = 7'd32;
      endcase
      write_entries_in_use(entries);
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      for (int n = 0; n < SegmentItems; n++) begin
        // Midway the sender holds off until all owed results are back.
        if (n == SegmentItems / 2) wait_results_drained();
        if ($urandom_range(99) < 20) begin
          rt  = kmp_pkg::ReqLoad;
          idx = kmp_pkg::EntryIdxW'($urandom_range(63));
          key = ($urandom_range(4) == 0) ? $urandom : key_pool[$urandom_range(7)];
          eob = 1'($urandom_range(1));
        end else begin
          rt  = kmp_pkg::ReqProbe;
          idx = kmp_pkg::EntryIdxW'($urandom);
          key = ($urandom_range(6) == 0) ? $urandom : key_pool[$urandom_range(7)];
          eob = ($urandom_range(4) == 0);
        end
        issue_request(rt, idx, key, eob);
      end
    end

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.pending());
      tracker.mismatch_count++;
    end
    if (tracker.mismatch_count == 0) begin
      $display("tb_key_match_probe_unit: clean");
    end else begin
      $display("tb_key_match_probe_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
